// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lse_pkg.sv =====
// ---------------------------------------------------------------------------
// lse_pkg
// Shared constants, types and helpers of the LSB payload extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int HC_W        = $clog2(LENGTH_BITS + 1);
    localparam int TAKE_W      = 4;

    // register word indexes
    localparam logic REG_PAYLOAD_MASK = 1'b0;
    localparam logic [7:0] MASK_RESET = 8'h01;

    typedef struct packed {
        logic       valid;
        logic [7:0] plain_byte;
        logic       last_byte;
    } result_t;

    typedef struct packed {
        logic header_done;
        logic payload_done;
    } core_status_t;

    function automatic logic [TAKE_W-1:0] ones_in(input logic [7:0] v);
        logic [TAKE_W-1:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + TAKE_W'(v[k]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lse_core.sv =====
// ---------------------------------------------------------------------------
// lse_core
// Header length capture, bit unpack and byte assembly, one word per cycle while accept is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lse_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [7:0]                    color_byte,
    input  wire logic                          image_start,
    input  wire logic [lse_pkg::TAKE_W-1:0]    take,
    output lse_pkg::result_t                   result,
    output lse_pkg::core_status_t              status
);

    localparam int LB = lse_pkg::LENGTH_BITS;
    localparam int HW = lse_pkg::HC_W;
    localparam int TW = lse_pkg::TAKE_W;

    logic [HW-1:0] header_count_reg, header_count_next;
    logic [LB-1:0] payload_length_reg, payload_length_next;
    logic [7:0]    partial_byte_reg, partial_byte_next;
    logic [2:0]    bit_position_reg, bit_position_next;
    logic [LB-1:0] bytes_emitted_reg, bytes_emitted_next;

    logic [HW-1:0] eff_hc;
    logic [LB-1:0] eff_len, eff_emit, emit_inc;
    logic [7:0]    eff_part, out_byte;
    logic [2:0]    eff_pos, d;
    logic          in_header, active, complete;
    logic [TW-1:0] eff_take, pos_sum;

    always_comb begin
        // start of image clears state before this word is used
        eff_hc   = image_start ? '0 : header_count_reg;
        eff_len  = image_start ? '0 : payload_length_reg;
        eff_part = image_start ? '0 : partial_byte_reg;
        eff_pos  = image_start ? '0 : bit_position_reg;
        eff_emit = image_start ? '0 : bytes_emitted_reg;

        in_header = eff_hc < HW'(LB);
        active    = !in_header && (eff_emit != eff_len);
        eff_take  = active ? take : '0;
        pos_sum   = TW'(eff_pos) + eff_take;
        complete  = pos_sum[TW-1];
        emit_inc  = eff_emit + LB'(1);

        header_count_next   = in_header ? eff_hc + HW'(1) : eff_hc;
        payload_length_next = eff_len;
        for (int k = 0; k < LB; k++) begin
            if (in_header && (eff_hc == HW'(k)) && color_byte[0]) begin
                payload_length_next[k] = 1'b1;
            end
        end

        d = '0;
        for (int i = 0; i < 8; i++) begin
            d = 3'(i) - eff_pos;
            partial_byte_next[i] = (TW'(d) < eff_take) ? color_byte[d] : eff_part[i];
            out_byte[i] = (3'(i) >= eff_pos) ? color_byte[d] : eff_part[i];
        end

        bit_position_next  = pos_sum[2:0];
        bytes_emitted_next = complete ? emit_inc : eff_emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg   <= '0;
            payload_length_reg <= '0;
            partial_byte_reg   <= '0;
            bit_position_reg   <= '0;
            bytes_emitted_reg  <= '0;
        end else if (accept) begin
            header_count_reg   <= header_count_next;
            payload_length_reg <= payload_length_next;
            partial_byte_reg   <= partial_byte_next;
            bit_position_reg   <= bit_position_next;
            bytes_emitted_reg  <= bytes_emitted_next;
        end
    end

    assign result.valid      = accept && complete;
    assign result.plain_byte = out_byte;
    assign result.last_byte  = (emit_inc == eff_len);

    assign status.header_done  = !in_header;
    assign status.payload_done = !in_header && !active;

endmodule

`default_nettype wire

// ===== hw/rtl/lse_out_buf.sv =====
// ---------------------------------------------------------------------------
// lse_out_buf
// Output register plus skid stage for the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module lse_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  lse_pkg::result_t       result,
    output logic                   in_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_plain_byte,
    output logic                   m_last_byte,
    output logic                   skid_full
);

    logic       out_valid_reg, skid_valid_reg;
    logic [7:0] out_byte_reg, skid_byte_reg;
    logic       out_last_reg, skid_last_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_ready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (result.valid) begin
                out_valid_reg  <= out_free ? 1'b1 : out_valid_reg;
                skid_valid_reg <= !out_free;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_byte_reg <= skid_byte_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (result.valid) begin
            if (out_free) begin
                out_byte_reg <= result.plain_byte;
                out_last_reg <= result.last_byte;
            end else begin
                skid_byte_reg <= result.plain_byte;
                skid_last_reg <= result.last_byte;
            end
        end
    end

    assign in_ready     = !skid_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_plain_byte = out_byte_reg;
    assign m_last_byte  = out_last_reg;
    assign skid_full    = skid_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_stego_extractor_top.sv =====
// ---------------------------------------------------------------------------
// lsb_stego_extractor_top
// Recovers a payload hidden in the low bits of cover-image color bytes.
// ---------------------------------------------------------------------------
// Color bytes arrive one word per cycle on s_* in the host's traversal order.
// The first 64 words of an image (s_image_start on the first one) supply a
// 64-bit byte count, one LSB each, LSB first. Every later word supplies its
// low popcount(payload_mask) bits, packed LSB first into payload bytes that
// leave on m_*, the final one with m_last_byte set. Once the count is met,
// input words are accepted and dropped until the next s_image_start.
// Rate: one word per cycle sustained while s_ready is high. State update and
// bit unpack of a word happen together; each completed byte is registered (in
// the output register, or the skid if that is held) for m_*. A two-entry
// output buffer (output register + skid) lets s_ready stay high while one
// result waits; s_ready drops only when both entries are full.
// payload_mask sits at byte address 0 (reset 1) and should only be written
// while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsb_stego_extractor_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // color byte stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_color_byte,
    input  wire logic        s_image_start,
    // payload byte stream
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_plain_byte,
    output logic             m_last_byte
);

    logic [7:0]                     payload_mask_reg;
    logic [lse_pkg::TAKE_W-1:0]     take;
    logic                           cfg_write, accept, skid_full;
    lse_pkg::result_t               result;
    lse_pkg::core_status_t          status;

    // config: word index is paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_mask_reg <= lse_pkg::MASK_RESET;
        end else if (cfg_write && (paddr[2] == lse_pkg::REG_PAYLOAD_MASK)) begin
            payload_mask_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            lse_pkg::REG_PAYLOAD_MASK: prdata = {24'd0, payload_mask_reg};
            default:                   prdata = '0;
        endcase
    end

    // bits taken per payload word
    assign take   = lse_pkg::ones_in(payload_mask_reg);
    assign accept = s_valid && s_ready;

    lse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .color_byte  (s_color_byte),
        .image_start (s_image_start),
        .take        (take),
        .result      (result),
        .status      (status)
    );

    lse_out_buf u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .result       (result),
        .in_ready     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_plain_byte (m_plain_byte),
        .m_last_byte  (m_last_byte),
        .skid_full    (skid_full)
    );

    // a result never comes out of a header word or a finished image
    `ASSERT_NEVER(a_no_result_in_header, aclk, aresetn,
        result.valid && (!status.header_done || status.payload_done),
        "result produced outside payload phase")
    // skid holds data only behind a full output register
    `ASSERT_NEVER(a_skid_behind_out, aclk, aresetn, skid_full && !m_valid,
        "skid entry with empty output register")
    // after a produced result, m_valid is high in the next cycle
    `ASSERT_NEXT(a_result_visible, aclk, aresetn, result.valid, m_valid,
        "produced result not presented")

endmodule

`default_nettype wire

// ===== verif/lsb_stego_extractor_top_tb.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor_top_tb
// Self-checking bench for the LSB payload extractor.
// ----------------------------------------------------------------------------
// A short table of directed words runs first. It covers mask 1 and mask FF
// decoding, zero length, a length with bit 63 set, a mask with no bits set,
// and mask changes in the middle of a payload. Random images follow. Most
// are well-formed (header plus enough payload words), and the rest are cut
// headers or huge lengths that simply stop. Every accepted color word goes
// through a local model of the extractor. Each payload word on m_* is
// compared with the oldest expected one. Each mask write is read back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_extractor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // mask register address: byte offset of its word index
    localparam logic [2:0] MASK_ADDR = 3'(4 * int'(lse_pkg::REG_PAYLOAD_MASK));
    localparam int PHASE_WORDS    = 480;   // random color words per idling phase
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int DRAIN_PAUSE    = 4;     // pause after the drain, before a mask write
    localparam int END_PAUSE      = 20;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] plain;
        logic       last;
    } plain_word_t;

    typedef enum logic [1:0] {ROW_MASK, ROW_HDR, ROW_WORD} row_kind_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_WORD} exp_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [63:0] arg;      // mask value or header length
        logic [7:0]  color;
        logic        start;
        exp_kind_t   ek;
        plain_word_t exp;      // typed expectation for EXP_WORD rows
    } dir_row_t;

    // ---------------------------------------------------------------- DUT I/O
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_color_byte  = '0;
    logic        s_image_start = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_plain_byte;
    logic        m_last_byte;

    lsb_stego_extractor_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_color_byte  (s_color_byte),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plain_byte  (m_plain_byte),
        .m_last_byte   (m_last_byte)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------- extractor model
    logic [7:0]  ext_mask  = lse_pkg::MASK_RESET;
    logic [6:0]  hdr_cnt   = '0;
    logic [63:0] pay_len   = '0;
    logic [7:0]  part_byte = '0;
    logic [2:0]  bit_pos   = '0;
    logic [63:0] emitted   = '0;

    plain_word_t plain_q[$];   // payload words still owed by the DUT
    dir_row_t    dir_tab[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  fail_cnt      = 0;
    int  words_in      = 0;
    int  words_out     = 0;
    int  mask_writes   = 0;
    int  images_sent   = 0;
    int  input_stalls  = 0;
    int  quiet_cycles  = 0;

    // One color word through the extractor. got is set when a payload byte
    // completes. At most one byte can complete per word (take <= 8).
    function automatic void extract_word(input logic [7:0] c, input logic st,
                                         output bit got, output plain_word_t w);
        int take;
        got = 1'b0;
        w   = '0;
        if (st) begin
            hdr_cnt   = '0;
            pay_len   = '0;
            part_byte = '0;
            bit_pos   = '0;
            emitted   = '0;
        end
        if (hdr_cnt < lse_pkg::LENGTH_BITS) begin
            pay_len[hdr_cnt[5:0]] = c[0];
            hdr_cnt++;
        end else if (emitted < pay_len) begin
            take = $countones(ext_mask);
            for (int j = 0; j < take; j++) begin
                part_byte[bit_pos] = c[j];
                if (bit_pos == 3'd7) begin
                    bit_pos = '0;
                    emitted++;
                    w   = '{plain: part_byte, last: (emitted == pay_len)};
                    got = 1'b1;
                    // leftover bits of this color word are dropped
                    if (emitted == pay_len) break;
                end else begin
                    bit_pos++;
                end
            end
        end
    endfunction

    function automatic dir_row_t tab_row(row_kind_t k, logic [63:0] a, logic [7:0] c,
                                         logic st, exp_kind_t ek, plain_word_t e);
        dir_row_t r;
        r.kind  = k;
        r.arg   = a;
        r.color = c;
        r.start = st;
        r.ek    = ek;
        r.exp   = e;
        return r;
    endfunction

    function automatic logic [7:0] pick_mask();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'h00;
        if (r < 30) return 8'hFF;
        if (r < 50) return 8'h01;
        return 8'($urandom);
    endfunction

    task automatic flag_error(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------ drivers
    // Offer one color word; valid holds until the handshake, then the model
    // runs and any expectation (predicted or typed) is queued.
    task automatic send_word(input logic [7:0] c, input logic st,
                             input exp_kind_t ek, input plain_word_t typed);
        bit          got;
        plain_word_t w;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_color_byte  <= c;
        s_image_start <= st;
        do @(posedge aclk); while (s_ready !== 1'b1);
        extract_word(c, st, got, w);
        words_in++;
        case (ek)
            EXP_PRED: if (got) plain_q.push_back(w);
            EXP_WORD: plain_q.push_back(typed);
            default: ;
        endcase
    endtask

    // n header words carrying len LSB first; random upper bits
    task automatic send_header(input logic [63:0] len, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c    = 8'($urandom);
            c[0] = len[i];
            send_word(c, (i == 0), EXP_PRED, '0);
        end
        images_sent++;
    endtask

    task automatic check_mask_readback();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MASK_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== {24'd0, ext_mask})
            flag_error($sformatf("mask readback exp %08h got %08h",
                                 {24'd0, ext_mask}, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mask writes only with the block idle: input dropped, all payload
    // words out, plus a pause for words that produced nothing.
    task automatic change_mask(input logic [7:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MASK_ADDR;
        pwdata  <= {24'd0, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        ext_mask = v;
        mask_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_mask_readback();
    endtask

    // One random image. hdr_words < LENGTH_BITS gives a cut header; the
    // mask may change at payload word change_at (-1: never).
    task automatic run_image(input logic [63:0] len, input int hdr_words,
                             input int change_at);
        int words;
        int zero_run;
        int cap;
        send_header(len, hdr_words);
        if (hdr_words >= lse_pkg::LENGTH_BITS) begin
            // huge lengths just stop partway (stream ends early)
            cap      = (len > 64'd40) ? $urandom_range(1, 30) : int'(len) * 8 + 4;
            words    = 0;
            zero_run = 0;
            while (emitted < pay_len && words < cap && zero_run < 6) begin
                if (words == change_at) change_mask(pick_mask());
                send_word(8'($urandom), 1'b0, EXP_PRED, '0);
                words++;
                if (ext_mask == 8'h00) zero_run++;
            end
            // trailing words; once the payload is complete the block drops them
            repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0, EXP_PRED, '0);
        end
    endtask

    // ------------------------------------------------------------ receiver
    // Random back-pressure; on request one long hold-off so the output
    // buffer fills and s_ready drops while the sender keeps offering.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------ checker
    always @(posedge aclk) begin
        plain_word_t e;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            words_out++;
            if (plain_q.size() == 0) begin
                flag_error($sformatf("unexpected payload word %02h last %b",
                                     m_plain_byte, m_last_byte));
            end else begin
                e = plain_q.pop_front();
                if (m_plain_byte !== e.plain || m_last_byte !== e.last)
                    flag_error($sformatf("payload word %0d exp %02h/%b got %02h/%b",
                                         words_out, e.plain, e.last,
                                         m_plain_byte, m_last_byte));
            end
        end
    end

    // ------------------------------------------------------------ watchdog
    always @(posedge aclk) begin
        if (s_valid && s_ready === 1'b0) input_stalls++;
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("lsb_stego_extractor_top_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------ main flow
    initial begin
        int phase_base;
        int r;
        int hdr_words;
        int change_at;
        logic [63:0] len;

        // directed table
        // mask 1: eight LSBs 0,1,1,0,1,0,0,1 -> 0x96, sole byte of the payload
        dir_tab.push_back(tab_row(ROW_HDR,  64'd1, '0, 1'b1, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hFE, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h01, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hFF, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h00, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h81, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h7E, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h80, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h3F, 1'b0, EXP_WORD, {8'h96, 1'b1}));
        // payload complete: ignored
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hFF, 1'b0, EXP_NONE, '0));
        // full mask: each color word is a payload byte
        dir_tab.push_back(tab_row(ROW_MASK, 64'hFF, '0, 1'b0, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_HDR,  64'd3, '0, 1'b1, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h00, 1'b0, EXP_WORD, {8'h00, 1'b0}));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hFF, 1'b0, EXP_WORD, {8'hFF, 1'b0}));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hA5, 1'b0, EXP_WORD, {8'hA5, 1'b1}));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h5A, 1'b0, EXP_NONE, '0));
        // zero length: nothing ever comes out
        dir_tab.push_back(tab_row(ROW_HDR,  64'd0, '0, 1'b1, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h77, 1'b0, EXP_NONE, '0));
        // bit 63 of the length must be kept: one byte is not the last
        dir_tab.push_back(tab_row(ROW_HDR,  64'h8000_0000_0000_0001, '0, 1'b1,
                                  EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h34, 1'b0, EXP_WORD, {8'h34, 1'b0}));
        // empty mask: payload words contribute nothing
        dir_tab.push_back(tab_row(ROW_MASK, 64'h00, '0, 1'b0, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hFF, 1'b0, EXP_NONE, '0));
        // mask changes mid-payload: one bit (lowest, not bit 7), then eight
        dir_tab.push_back(tab_row(ROW_MASK, 64'h80, '0, 1'b0, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'h01, 1'b0, EXP_PRED, '0));
        dir_tab.push_back(tab_row(ROW_MASK, 64'hFF, '0, 1'b0, EXP_NONE, '0));
        dir_tab.push_back(tab_row(ROW_WORD, '0, 8'hC3, 1'b0, EXP_PRED, '0));

        send_idle_pct = 15;
        recv_idle_pct = 49;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        check_mask_readback();   // reset value

        foreach (dir_tab[i]) begin
            case (dir_tab[i].kind)
                ROW_MASK: change_mask(dir_tab[i].arg[7:0]);
                ROW_HDR:  send_header(dir_tab[i].arg, lse_pkg::LENGTH_BITS);
                default:  send_word(dir_tab[i].color, dir_tab[i].start,
                                    dir_tab[i].ek, dir_tab[i].exp);
            endcase
        end

        // random images, three idling profiles
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 15 : (p == 1) ? 49 : 0;
            recv_idle_pct = (p == 0) ? 49 : (p == 1) ? 15 : 0;
            phase_base    = words_in;
            if (p == 2) begin
                // long stall with a long payload behind it
                change_mask(8'hFF);
                hold_req = 1'b1;
                run_image(64'd40, lse_pkg::LENGTH_BITS, -1);
            end
            while (words_in - phase_base < PHASE_WORDS) begin
                if ($urandom_range(99) < 40) change_mask(pick_mask());
                hdr_words = lse_pkg::LENGTH_BITS;
                change_at = ($urandom_range(99) < 20) ? $urandom_range(0, 24) : -1;
                r = $urandom_range(99);
                if (r < 4) begin
                    len = 64'd0;
                end else if (r < 84) begin
                    len = 64'($urandom_range(1, 12));
                end else if (r < 92) begin
                    len = 64'($urandom_range(13, 40));
                end else if (r < 96) begin
                    // header cut short by the next image_start
                    len       = {$urandom, $urandom};
                    hdr_words = $urandom_range(1, lse_pkg::LENGTH_BITS - 1);
                end else begin
                    len = {$urandom, $urandom} | 64'h100;
                end
                run_image(len, hdr_words, change_at);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (END_PAUSE) @(posedge aclk);
        if (plain_q.size() != 0) flag_error("payload words still owed at end");

        $display("run: %0d color words over %0d images, %0d payload words checked",
                 words_in, images_sent, words_out);
        $display("     %0d mask writes, %0d input stall cycles, %0d errors",
                 mask_writes, input_stalls, fail_cnt);
        if (fail_cnt == 0) begin
            $display("lsb_stego_extractor_top_tb passed");
        end else begin
            $display("lsb_stego_extractor_top_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lse_pkg.sv
hw/rtl/lse_core.sv
hw/rtl/lse_out_buf.sv
hw/rtl/lsb_stego_extractor_top.sv
verif/lsb_stego_extractor_top_tb.sv
